FILE: rtl/core/time_key_sort_dedup_macros.svh
// assertion macros for the time key sort block
`ifndef TIME_KEY_SORT_DEDUP_MACROS_SVH
`define TIME_KEY_SORT_DEDUP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, clocked on i_clk, off during reset
`define TKSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tksd assertion failed");
// next-cycle implication
`define TKSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tksd assertion failed");
`else
`define TKSD_ASSERT_NOW(label, ante, cons)
`define TKSD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/tksd_pkg.sv
package tksd_pkg;

    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int KEY_W   = HOUR_W + MIN_W;
    localparam int POS_W   = 3;
    localparam int UCNT_W  = 4;

    // sort key: hour in the upper bits, minute below
    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic [HOUR_W-1:0] entry_hour;
        logic [MIN_W-1:0]  entry_minute;
        logic              entry_last;
    } t_entry;

    typedef struct packed {
        logic [HOUR_W-1:0] out_hour;
        logic [MIN_W-1:0]  out_minute;
        logic [POS_W-1:0]  out_position;
        logic [UCNT_W-1:0] unique_count;
        logic              overflowed;
        logic              out_last;
    } t_result;

endpackage

FILE: rtl/core/time_key_sort_dedup.sv
// Collects a batch of (hour, minute) entries and emits them sorted ascending with
// duplicates removed. A request is taken when start is high while busy is low; busy
// then stays high until the block can take the next one. The entries live in one
// two-port memory (one read with registered data and one write per cycle), kept
// sorted by an insertion pass: a scan upward from entry 0 to find the slot or a
// duplicate, a shift of the larger entries one place up, then a write of the new key.
// A dropped duplicate or overflow ends after the scan, with no shift and no write. A
// request marked entry_last then starts a priming read of entry 0, and the results
// come out on o_result with o_strobe high, one per cycle and in order, each in the
// cycle after its read. The receiver cannot stall: every strobed result must be taken
// in the cycle it is shown. Entries beyond MAX_ENTRIES are dropped and flagged on the
// results of that batch.
`include "time_key_sort_dedup_macros.svh"

module time_key_sort_dedup
    import tksd_pkg::*;
#(
    parameter int MAX_ENTRIES = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_entry  i_entry,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int AW = $clog2(MAX_ENTRIES);        // memory address width
    localparam int CW = $clog2(MAX_ENTRIES + 1);    // count, holds MAX_ENTRIES itself

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_PLACE,
        S_PRIME,
        S_EMIT
    } t_state;

    // entry store, sorted ascending over the first r_count entries
    t_key mem [MAX_ENTRIES];

    t_state  r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;        // scan / shift / emit index
    logic [CW-1:0] r_pos, n_pos;        // insertion slot
    logic [CW-1:0] r_count, n_count;    // held unique entries
    logic    r_ovf, n_ovf;              // entry dropped for lack of room
    t_key    r_key, n_key;              // key of the request in work
    logic    r_last, n_last;            // request closes the batch
    logic    r_strobe, n_strobe;
    t_result r_res, n_res;
    t_key    r_rdata;                   // mem[r_idx] as of the previous edge

    // write port
    logic          w_we;
    logic [AW-1:0] w_addr;
    t_key          w_data;

    logic w_full;
    logic w_done;

    assign w_full = (r_count == CW'(MAX_ENTRIES));

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_key    = r_key;
        n_last   = r_last;
        n_strobe = 1'b0;
        n_res    = r_res;
        w_we     = 1'b0;
        w_addr   = r_pos[AW-1:0];
        w_data   = r_key;
        w_done   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key  = {i_entry.entry_hour, i_entry.entry_minute};
                    n_last = i_entry.entry_last;
                    n_idx  = '0;
                    n_pos  = '0;
                    // empty store: the first entry goes straight to slot 0
                    n_state = (r_count == '0) ? S_PLACE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_rdata == r_key) begin
                    // duplicate, nothing to store
                    w_done = 1'b1;
                end else if (r_rdata > r_key) begin
                    if (w_full) begin
                        n_ovf  = 1'b1;
                        w_done = 1'b1;
                    end else begin
                        n_pos   = r_idx;
                        n_idx   = r_count - 1'b1;
                        n_state = S_SHIFT;
                    end
                end else if (CW'(r_idx + 1'b1) == r_count) begin
                    // larger than every held entry: append
                    if (w_full) begin
                        n_ovf  = 1'b1;
                        w_done = 1'b1;
                    end else begin
                        n_pos   = r_count;
                        n_state = S_PLACE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SHIFT: begin
                // move one entry up; the read of the next lower one overlaps
                w_we   = 1'b1;
                w_addr = AW'(r_idx + 1'b1);
                w_data = r_rdata;
                if (r_idx == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            S_PLACE: begin
                w_we    = 1'b1;
                w_addr  = r_pos[AW-1:0];
                w_data  = r_key;
                n_count = r_count + 1'b1;
                w_done  = 1'b1;
            end
            S_PRIME: begin
                // re-read entry 0 after the last write has landed
                n_idx   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_strobe           = 1'b1;
                n_res.out_hour     = r_rdata[KEY_W-1:MIN_W];
                n_res.out_minute   = r_rdata[MIN_W-1:0];
                n_res.out_position = POS_W'(r_idx);
                n_res.unique_count = UCNT_W'(r_count);
                n_res.overflowed   = r_ovf;
                n_res.out_last     = (CW'(r_idx + 1'b1) == r_count);
                if (CW'(r_idx + 1'b1) == r_count) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_done) begin
            n_idx   = '0;
            n_state = r_last ? S_PRIME : S_IDLE;
        end
    end

    // memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_data;
        end
        r_rdata <= mem[n_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
            r_idx    <= n_idx;
        end
        r_pos  <= n_pos;
        r_key  <= n_key;
        r_last <= n_last;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // store never holds more than its capacity
    `TKSD_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CW'(MAX_ENTRIES))
    // every emit cycle produces exactly one strobed result
    `TKSD_ASSERT_NEXT(a_emit_strobe, r_state == S_EMIT, r_strobe)
    // the final result of a batch leaves the block idle and empty
    `TKSD_ASSERT_NOW(a_last_idle, r_strobe && r_res.out_last,
        r_state == S_IDLE && r_count == '0)
    // the shift never walks below the insertion slot
    `TKSD_ASSERT_NOW(a_shift_range, r_state == S_SHIFT, r_idx >= r_pos)

endmodule

FILE: verif/tb_time_key_sort_dedup.sv
module tb_time_key_sort_dedup
    import tksd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // store size under test, also passed to the block
    localparam int MAX_ENTRIES  = 8;
    // worst request: scan plus shift plus write, then a full emit of the store
    localparam int DRAIN_CYCLES = 3 * MAX_ENTRIES + 8;
    // generous ceiling on the whole run
    localparam int CYCLE_LIMIT  = 300000;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_entry  i_entry = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    time_key_sort_dedup #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_entry (i_entry),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // own copy of the sorted store: keys are {hour, minute}, ascending
    t_key    held_keys [MAX_ENTRIES];
    int      held_n;
    logic    store_overflow;

    // sorted unique entries still owed by the block, oldest first
    t_result due_entries [$];

    int      sender_idle_pct;
    int      mismatches = 0;
    int      requests_sent;
    int      batches_closed;
    int      overflow_batches;
    int      results_checked = 0;
    int      cycles = 0;

    // fold one accepted request into the store, queue the batch when it is the last
    function automatic void absorb_entry(t_entry e);
        t_key    k;
        int      pos;
        t_result r;
        begin
            k   = {e.entry_hour, e.entry_minute};
            pos = 0;
            // find the first held key that is not smaller
            while (pos < held_n && held_keys[pos] < k)
                pos++;
            // equal key already held: dropped, no slot, no overflow
            if (!(pos < held_n && held_keys[pos] == k)) begin
                if (held_n >= MAX_ENTRIES) begin
                    // store full: new unique key is lost and flagged
                    store_overflow = 1'b1;
                end else begin
                    for (int i = held_n; i > pos; i--)
                        held_keys[i] = held_keys[i-1];
                    held_keys[pos] = k;
                    held_n++;
                end
            end
            if (e.entry_last) begin
                // batch end: one result per held key, in ascending order
                for (int i = 0; i < held_n; i++) begin
                    r.out_hour     = held_keys[i][KEY_W-1:MIN_W];
                    r.out_minute   = held_keys[i][MIN_W-1:0];
                    r.out_position = POS_W'(i);
                    r.unique_count = UCNT_W'(held_n);
                    r.overflowed   = store_overflow;
                    r.out_last     = (i == held_n - 1);
                    due_entries.push_back(r);
                end
                batches_closed++;
                if (store_overflow)
                    overflow_batches++;
                held_n         = 0;
                store_overflow = 1'b0;
            end
        end
    endfunction

    function automatic t_entry make_entry(int hour, int minute, bit last);
        t_entry e;
        begin
            e.entry_hour   = HOUR_W'(hour);
            e.entry_minute = MIN_W'(minute);
            e.entry_last   = last;
            return e;
        end
    endfunction

    // offer one request until the block takes it; the sender may back off any cycle
    task automatic send_entry(input t_entry e);
        bit taken;
        bit go;
        begin
            taken = 1'b0;
            while (!taken) begin
                @(negedge i_clk);
                go = ($urandom_range(0, 99) >= sender_idle_pct);
                start   <= go;
                i_entry <= e;
                @(posedge i_clk);
                taken = go && !busy;
            end
            requests_sent++;
            absorb_entry(e);
        end
    endtask

    // lower start once nothing more is to be offered
    task automatic stop_sending();
        begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        begin
            $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // every strobed result is taken in its own cycle and matched against the oldest due one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (o_strobe !== 1'b1) begin
                $display("%0t ns: strobe expected 0 or 1 got %b", $time, o_strobe);
                mismatches++;
            end else if (due_entries.size() == 0) begin
                $display("%0t ns: result expected none got hour %0d minute %0d",
                         $time, o_result.out_hour, o_result.out_minute);
                mismatches++;
            end else begin
                want = due_entries.pop_front();
                results_checked++;
                if (o_result.out_hour !== want.out_hour)
                    flag_mismatch("out_hour", want.out_hour, o_result.out_hour);
                if (o_result.out_minute !== want.out_minute)
                    flag_mismatch("out_minute", want.out_minute, o_result.out_minute);
                if (o_result.out_position !== want.out_position)
                    flag_mismatch("out_position", want.out_position, o_result.out_position);
                if (o_result.unique_count !== want.unique_count)
                    flag_mismatch("unique_count", want.unique_count, o_result.unique_count);
                if (o_result.overflowed !== want.overflowed)
                    flag_mismatch("overflowed", want.overflowed, o_result.overflowed);
                if (o_result.out_last !== want.out_last)
                    flag_mismatch("out_last", want.out_last, o_result.out_last);
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycles, due_entries.size());
            $display("time_key_sort_dedup regression: fail");
            $finish;
        end
    end

    // a batch of one entry
    task automatic test_single_entry();
        begin
            send_entry(make_entry(12, 34, 1'b1));
        end
    endtask

    // all-ones and all-zero fields, out-of-range hours and minutes, out-of-order arrival
    task automatic test_extremes_and_order();
        begin
            send_entry(make_entry(31, 63, 1'b0));
            send_entry(make_entry(0, 0, 1'b0));
            send_entry(make_entry(24, 60, 1'b0));
            send_entry(make_entry(23, 59, 1'b0));
            send_entry(make_entry(0, 63, 1'b1));
        end
    endtask

    // repeated key collapses to one result, also when the repeat closes the batch
    task automatic test_duplicates();
        begin
            send_entry(make_entry(5, 30, 1'b0));
            send_entry(make_entry(5, 30, 1'b0));
            send_entry(make_entry(5, 30, 1'b1));
        end
    endtask

    // fill the store in descending order, repeat a held key, then one key too many
    task automatic test_full_store();
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
                send_entry(make_entry(20 - i, 7 * i, 1'b0));
            send_entry(make_entry(20, 0, 1'b0));
            send_entry(make_entry(1, 1, 1'b1));
        end
    endtask

    // random batches: narrow key pools invite duplicates, long batches invite overflow
    task automatic test_random_batches(input int idle_pct, input int n_requests);
        int stop_at;
        int len;
        bit narrow;
        int hour_base;
        begin
            sender_idle_pct = idle_pct;
            stop_at = requests_sent + n_requests;
            while (requests_sent < stop_at) begin
                if ($urandom_range(0, 9) < 2)
                    len = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 5);
                else
                    len = $urandom_range(1, MAX_ENTRIES);
                narrow    = ($urandom_range(0, 9) < 4);
                hour_base = $urandom_range(0, 29);
                for (int i = 0; i < len; i++) begin
                    if (narrow)
                        send_entry(make_entry(hour_base + $urandom_range(0, 2),
                                              $urandom_range(0, 3), i == len - 1));
                    else
                        send_entry(make_entry($urandom_range(0, 31),
                                              $urandom_range(0, 63), i == len - 1));
                end
            end
        end
    endtask

    initial begin
        held_n           = 0;
        store_overflow   = 1'b0;
        sender_idle_pct  = 0;
        requests_sent    = 0;
        batches_closed   = 0;
        overflow_batches = 0;

        // synchronous reset held from the start, released on a falling edge
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_entry();
        test_extremes_and_order();
        test_duplicates();
        test_full_store();

        // sender backs off now and then, then often, then never
        test_random_batches(27, 45);
        test_random_batches(48, 45);
        test_random_batches(0, 40);
        stop_sending();

        // let every owed result come out, then watch for strays
        while (due_entries.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests in %0d batches, %0d of them past store capacity",
                 requests_sent, batches_closed, overflow_batches);
        $display("checked %0d sorted results with idle rates of 0, 27 and 48 percent",
                 results_checked);
        if (mismatches == 0 && due_entries.size() == 0) begin
            $display("time_key_sort_dedup regression: pass");
        end else begin
            $display("time_key_sort_dedup regression: fail");
        end
        $finish;
    end

endmodule
